/* rtl/core/wtra_pkg.sv */
// Shared types and constants for the windowed tilt roll angle block.
// Used by the channel interfaces, the roll unit and the top level.
package wtra_pkg;

    localparam int ACCEL_W      = 16;
    localparam int ROLL_W       = 15;
    localparam int ANGLE_W      = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 20;
    localparam int ROOT_FRAC    = 10;
    localparam int ROLL_MAX     = 9000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_ROLL
    } t_state;

    typedef enum logic [2:0] {
        R_IDLE,
        R_SQX,
        R_SQZ,
        R_ADD,
        R_SQRT,
        R_INIT,
        R_CORDIC,
        R_DONE
    } t_roll_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_roll_ctl;

    typedef struct packed {
        logic                     done;
        logic signed [ROLL_W-1:0] roll;
    } t_roll_stat;

    // atan(2^-i) in sixteenths of a centidegree, rounded to nearest.
    function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [3:0] idx);
        logic signed [ANGLE_W-1:0] v;
        unique case (idx)
            4'd0:    v = ANGLE_W'(72000);
            4'd1:    v = ANGLE_W'(42504);
            4'd2:    v = ANGLE_W'(22458);
            4'd3:    v = ANGLE_W'(11400);
            4'd4:    v = ANGLE_W'(5722);
            4'd5:    v = ANGLE_W'(2864);
            4'd6:    v = ANGLE_W'(1432);
            4'd7:    v = ANGLE_W'(716);
            4'd8:    v = ANGLE_W'(358);
            4'd9:    v = ANGLE_W'(179);
            4'd10:   v = ANGLE_W'(90);
            4'd11:   v = ANGLE_W'(45);
            4'd12:   v = ANGLE_W'(22);
            4'd13:   v = ANGLE_W'(11);
            4'd14:   v = ANGLE_W'(6);
            4'd15:   v = ANGLE_W'(3);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/wtra_sample_if.sv */
// Sample channel: one accelerometer word of three axes plus the batch end flag.
// Depends on wtra_pkg for the axis width.
interface wtra_sample_if import wtra_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      last_sample;

    modport source(output valid, output accel_x, output accel_y, output accel_z,
                   output last_sample, input ready);
    modport sink(input valid, input accel_x, input accel_y, input accel_z,
                 input last_sample, output ready);
endinterface

/* rtl/core/wtra_roll_if.sv */
// Result channel: one roll angle word in centidegrees plus the batch end flag.
// Depends on wtra_pkg for the result width.
interface wtra_roll_if import wtra_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ROLL_W-1:0] roll_centidegrees;
    logic                     last_result;

    modport source(output valid, output roll_centidegrees, output last_result,
                   input ready);
    modport sink(input valid, input roll_centidegrees, input last_result,
                 output ready);
endinterface

/* rtl/core/windowed_tilt_roll_angle.sv */
// Windowed roll angle from a batch of three-axis accelerometer words.
// Depends on wtra_pkg, wtra_sample_if, wtra_roll_if and wtra_roll.
//
// Usage:
//   i_sample carries one accelerometer word per handshake; last_sample ends a
//   batch. o_roll carries one roll angle word in centidegrees for every window
//   of WINDOW words that lies wholly before the newest DISCARD words; the
//   window ending at word k is released when word k+DISCARD arrives, and
//   last_result marks the word caused by the batch's last sample.
//   The history lives in one memory of WINDOW+DISCARD entries, read at the
//   slot to overwrite and the slot entering the window, and written in the
//   following cycle while the three running sums are updated.
//   Steps: a word that gives no result is only accepted and summed. A word
//   that gives a result then goes through the squares and add, a bit-serial
//   square root with one root bit per cycle, a setup step and 16 CORDIC
//   steps, all skipped when its y sum is zero, and the result is handed over.
//   One word is in work at a time; the next one is taken as soon as the
//   result has moved to the output register.
//   Reset clears the sums, counters and handshakes; the history memory is not
//   cleared, since a batch only reads entries it has written itself.
//   When the receiver stalls, the result waits in the output register; a
//   further result waits inside the roll unit, and no new word is taken.
module windowed_tilt_roll_angle import wtra_pkg::*; #(
    parameter int WINDOW  = 20,
    parameter int DISCARD = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wtra_sample_if.sink   i_sample,
    wtra_roll_if.source   o_roll
);

    localparam int HIST_LEN = WINDOW + DISCARD;
    localparam int AW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int SCW      = $clog2(HIST_LEN + 1);
    localparam int SUM_W    = ACCEL_W + $clog2(WINDOW) + 1;
    localparam int WORD_W   = 3 * ACCEL_W;

    t_state r_state, n_state;

    logic [WORD_W-1:0] mem_hist [HIST_LEN];
    logic [WORD_W-1:0] r_old_rd, r_add_rd;
    logic [WORD_W-1:0] r_in_word;
    logic              r_last, r_emit;
    logic [SCW-1:0]    r_seen;
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     q_addr;
    logic [AW:0]       wp_ext;

    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic signed [SUM_W-1:0] n_sum_x, n_sum_y, n_sum_z;
    logic [WORD_W-1:0]       add_word;
    logic                    use_add, use_old;

    logic              r_out_valid;
    logic signed [ROLL_W-1:0] r_out_roll;
    logic              r_out_last;
    logic              out_free;

    t_roll_ctl  roll_ctl;
    t_roll_stat roll_stat;

    // Slot of the word that enters the window, DISCARD places behind the write slot.
    always_comb begin
        wp_ext = {1'b0, r_wp};
        if (wp_ext >= (AW+1)'(DISCARD)) begin
            q_addr = AW'(wp_ext - (AW+1)'(DISCARD));
        end else begin
            q_addr = AW'(wp_ext + (AW+1)'(HIST_LEN - DISCARD));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            mem_hist[r_wp] <= r_in_word;
        end
        r_old_rd <= mem_hist[r_wp];
        r_add_rd <= mem_hist[q_addr];
    end

    always_comb begin
        add_word = (DISCARD == 0) ? r_in_word : r_add_rd;
        use_add  = (r_seen >= SCW'(DISCARD));
        use_old  = (r_seen >= SCW'(HIST_LEN));
        n_sum_x  = r_sum_x
                 + (use_add ? SUM_W'($signed(add_word[3*ACCEL_W-1 -: ACCEL_W])) : '0)
                 - (use_old ? SUM_W'($signed(r_old_rd[3*ACCEL_W-1 -: ACCEL_W])) : '0);
        n_sum_y  = r_sum_y
                 + (use_add ? SUM_W'($signed(add_word[2*ACCEL_W-1 -: ACCEL_W])) : '0)
                 - (use_old ? SUM_W'($signed(r_old_rd[2*ACCEL_W-1 -: ACCEL_W])) : '0);
        n_sum_z  = r_sum_z
                 + (use_add ? SUM_W'($signed(add_word[ACCEL_W-1:0])) : '0)
                 - (use_old ? SUM_W'($signed(r_old_rd[ACCEL_W-1:0])) : '0);
    end

    assign out_free = !r_out_valid || o_roll.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        i_sample.ready = 1'b0;
        roll_ctl.start = 1'b0;
        roll_ctl.take  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No word is taken while reset is held.
                i_sample.ready = i_rst_n;
                if (i_sample.valid) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                roll_ctl.start = r_emit;
                n_state        = r_emit ? S_ROLL : S_IDLE;
            end
            S_ROLL: begin
                if (roll_stat.done && out_free) begin
                    roll_ctl.take = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_word <= {i_sample.accel_x, i_sample.accel_y, i_sample.accel_z};
            r_last    <= i_sample.last_sample;
            // A batch of exactly WINDOW+DISCARD words ends without a result.
            r_emit    <= (r_seen >= SCW'(HIST_LEN - 1))
                         && !(i_sample.last_sample && r_seen == SCW'(HIST_LEN - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_seen  <= '0;
            r_wp    <= '0;
        end else if (r_state == S_SUM) begin
            if (r_last) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_seen  <= '0;
                r_wp    <= '0;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_sum_z <= n_sum_z;
                if (r_seen < SCW'(HIST_LEN)) begin
                    r_seen <= r_seen + 1'b1;
                end
                r_wp <= (r_wp == AW'(HIST_LEN - 1)) ? '0 : r_wp + 1'b1;
            end
        end
    end

    wtra_roll #(
        .SUM_W(SUM_W)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (roll_ctl),
        .i_sum_x (n_sum_x),
        .i_sum_y (n_sum_y),
        .i_sum_z (n_sum_z),
        .o_stat  (roll_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (roll_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (o_roll.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (roll_ctl.take) begin
            r_out_roll <= roll_stat.roll;
            r_out_last <= r_last;
        end
    end

    assign o_roll.valid             = r_out_valid;
    assign o_roll.roll_centidegrees = r_out_roll;
    assign o_roll.last_result       = r_out_last;

endmodule

/* rtl/core/wtra_roll.sv */
// Roll angle unit: squares, bit-serial square root and a 16-step CORDIC.
// Depends on wtra_pkg; started by the top level with the three window sums.
module wtra_roll import wtra_pkg::*; #(
    parameter int SUM_W = 22
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_roll_ctl               i_ctl,
    input  logic signed [SUM_W-1:0] i_sum_x,
    input  logic signed [SUM_W-1:0] i_sum_y,
    input  logic signed [SUM_W-1:0] i_sum_z,
    output t_roll_stat              o_stat
);

    localparam int SQ_W    = 2 * SUM_W;
    localparam int RAD_RAW = SQ_W + 1 + FRAC_BITS;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int CW      = ROOT_W + 13;
    localparam int CNT_W   = $clog2(ROOT_W);

    t_roll_state r_state, n_state;

    logic [SUM_W-1:0]        r_ax, r_ay, r_az;
    logic                    r_neg, r_yzero;
    logic [SQ_W-1:0]         r_sqa, r_sqb;
    logic [RAD_W-1:0]        r_rad;
    logic [REM_W-1:0]        r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CW-1:0]    r_x, r_y;
    logic signed [ANGLE_W-1:0] r_z;

    logic [REM_W-1:0]        rem_sh, trial;
    logic                    fits;
    logic signed [CW-1:0]    dx, dy;
    logic signed [ANGLE_W-1:0] step_ang;
    logic signed [ANGLE_W-1:0] rounded;
    logic [ROLL_W-1:0]       mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            R_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_sum_y == '0) ? R_DONE : R_SQX;
                end
            end
            R_SQX:  n_state = R_SQZ;
            R_SQZ:  n_state = R_ADD;
            R_ADD:  n_state = R_SQRT;
            R_SQRT: begin
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    n_state = R_INIT;
                end
            end
            R_INIT: n_state = R_CORDIC;
            R_CORDIC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = R_DONE;
                end
            end
            R_DONE: begin
                if (i_ctl.take) begin
                    n_state = R_IDLE;
                end
            end
            default: n_state = R_IDLE;
        endcase
    end

    // One root bit per cycle: restoring square root on two radicand bits.
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_comb begin
        dx       = r_y >>> r_cnt[3:0];
        dy       = r_x >>> r_cnt[3:0];
        step_ang = atan_step(r_cnt[3:0]);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            R_IDLE: begin
                r_ax    <= i_sum_x[SUM_W-1] ? SUM_W'(-i_sum_x) : SUM_W'(i_sum_x);
                r_ay    <= i_sum_y[SUM_W-1] ? SUM_W'(-i_sum_y) : SUM_W'(i_sum_y);
                r_az    <= i_sum_z[SUM_W-1] ? SUM_W'(-i_sum_z) : SUM_W'(i_sum_z);
                r_neg   <= i_sum_y[SUM_W-1];
                r_yzero <= (i_sum_y == '0);
            end
            R_SQX: r_sqa <= SQ_W'(r_ax) * SQ_W'(r_ax);
            R_SQZ: r_sqb <= SQ_W'(r_az) * SQ_W'(r_az);
            R_ADD: begin
                r_rad  <= RAD_W'({RAD_W'(r_sqa) + RAD_W'(r_sqb), FRAC_BITS'(0)});
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            R_SQRT: begin
                r_rem  <= fits ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], fits};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
            end
            R_INIT: begin
                r_x   <= $signed(CW'({r_root, ROOT_FRAC'(0)}));
                r_y   <= $signed(CW'({r_ay, FRAC_BITS'(0)}));
                r_z   <= '0;
                r_cnt <= '0;
            end
            R_CORDIC: begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + step_ang;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - step_ang;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            R_DONE: ;
            default: ;
        endcase
    end

    // A negative angle rounds to zero or below and is clamped to zero anyway.
    always_comb begin
        rounded = (r_z + ANGLE_W'(8)) >>> 4;
        if (r_yzero || r_z[ANGLE_W-1]) begin
            mag = '0;
        end else if (rounded > ANGLE_W'(ROLL_MAX)) begin
            mag = ROLL_W'(ROLL_MAX);
        end else begin
            mag = rounded[ROLL_W-1:0];
        end
        o_stat.done = (r_state == R_DONE);
        o_stat.roll = r_neg ? $signed(-mag) : $signed(mag);
    end

endmodule
